// ===== hdl/pse_pkg.sv =====
package pse_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 128;
    localparam int unsigned DATA_W          = 64;
    localparam int unsigned STATUS_W        = 3;

    // token commands
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_OP   = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // operator bytes
    localparam logic [7:0] SYM_ADD = 8'h2B;
    localparam logic [7:0] SYM_SUB = 8'h2D;
    localparam logic [7:0] SYM_MUL = 8'h2A;
    localparam logic [7:0] SYM_DIV = 8'h2F;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_DIV0     = 3'd2;
    localparam logic [2:0] ST_ILLEGAL  = 3'd3;
    localparam logic [2:0] ST_MANY     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    // start request to the arithmetic unit
    typedef struct packed {
        logic       start;
        logic       is_mul;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } t_alu_req;

    // magnitude with sign applied, saturated
    function automatic logic [63:0] signed_sat(input logic [63:0] mag, input logic neg,
                                               input logic over);
        logic [63:0] r;
        if (neg) begin
            if (over || mag > SIGN_MIN) r = SIGN_MIN;
            else r = ~mag + 64'd1;
        end else begin
            if (over || mag > POS_MAX) r = POS_MAX;
            else r = mag;
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

// ===== hdl/postfix_stack_evaluator.sv =====
// Channel  | Direction | Handshake              | Payload
// token    | in        | i_valid / o_ready      | i_command, i_operator_symbol, i_number_value
// result   | out       | o_valid / i_ready      | o_result_value, o_status
//
// Push is accepted, then written to the stack; end, overflow and too-few-operand errors finish
// on acceptance. Add and subtract read two stack entries, execute and write back; an illegal
// operator or a zero divisor ends with an error after the reads. Multiply sums four 32x32
// partial products; divide produces one quotient bit per cycle over 96 bits.
// Synchronous active-low reset clears count, error and control; stack RAM is not cleared.
// An end token waits while a previous result is still held in the output register.
module postfix_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_operator_symbol,
    input  logic signed [63:0] i_number_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [63:0] o_result_value,
    output logic [2:0]        o_status
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD2  = 4'b0010,
        S_EXE  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state       r_state;
    logic [CW-1:0] r_count;
    logic [2:0]   r_err;
    logic [7:0]   r_sym;
    logic [63:0]  r_op2;
    logic [63:0]  r_top;     // cached top of stack entry 0 for end token
    logic [63:0]  r_stack [STACK_DEPTH];
    logic [63:0]  r_rd;
    logic         r_we;
    logic [AW-1:0] r_waddr, r_raddr;
    logic [63:0]  r_wdata;
    logic         r_o_valid;
    logic [63:0]  r_o_value;
    logic [2:0]   r_o_status;
    logic         r_md_go;   // first cycle of S_WAIT, both operands in place

    pse_pkg::t_alu_req w_req;
    logic         w_done;
    logic [63:0]  w_res;
    logic [63:0]  w_sum, w_dif, w_add, w_sub;
    logic         w_acc;

    pse_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_result (w_res)
    );

    // stack memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_we) r_stack[r_waddr] <= r_wdata;
        r_rd <= r_stack[r_raddr];
    end

    assign o_ready = (r_state == S_IDLE) && !r_we &&
                     !(i_command == pse_pkg::CMD_END && r_o_valid);
    assign w_acc   = i_valid && o_ready;

    // saturating add and subtract of op1 (r_rd) and op2
    always_comb begin
        w_sum = r_rd + r_op2;
        w_dif = r_rd - r_op2;
        w_add = (!(r_rd[63] ^ r_op2[63]) && (w_sum[63] ^ r_rd[63])) ?
                (r_rd[63] ? pse_pkg::SIGN_MIN : pse_pkg::POS_MAX) : w_sum;
        w_sub = ((r_rd[63] ^ r_op2[63]) && (w_dif[63] ^ r_rd[63])) ?
                (r_rd[63] ? pse_pkg::SIGN_MIN : pse_pkg::POS_MAX) : w_dif;
        w_req.start  = r_md_go && (r_sym == pse_pkg::SYM_MUL ||
                       (r_sym == pse_pkg::SYM_DIV && r_op2 != 64'd0));
        w_req.is_mul = (r_sym == pse_pkg::SYM_MUL);
        w_req.op_a   = r_rd;
        w_req.op_b   = r_op2;
    end

    // token sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_err     <= pse_pkg::ST_OK;
            r_we      <= 1'b0;
            r_o_valid <= 1'b0;
            r_md_go   <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_md_go <= (r_state == S_EXE);
            if (r_o_valid && i_ready) r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_acc) begin
                    case (i_command)
                        pse_pkg::CMD_PUSH: if (r_err == pse_pkg::ST_OK) begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                r_err <= pse_pkg::ST_OVERFLOW;
                            end else begin
                                r_we    <= 1'b1;
                                r_waddr <= r_count[AW-1:0];
                                r_wdata <= i_number_value;
                                if (r_count == '0) r_top <= i_number_value;
                                r_count <= r_count + CW'(1);
                            end
                        end
                        pse_pkg::CMD_OP: if (r_err == pse_pkg::ST_OK) begin
                            if (r_count < CW'(2)) begin
                                r_count <= '0;
                                r_err   <= pse_pkg::ST_FEW;
                            end else begin
                                r_sym   <= i_operator_symbol;
                                r_raddr <= AW'(r_count - CW'(1));
                                r_count <= r_count - CW'(2);
                                r_state <= S_RD2;
                            end
                        end
                        pse_pkg::CMD_END: begin
                            r_o_valid <= 1'b1;
                            r_o_value <= 64'd0;
                            if (r_err != pse_pkg::ST_OK) r_o_status <= r_err;
                            else if (r_count == '0) r_o_status <= pse_pkg::ST_EMPTY;
                            else if (r_count > CW'(1)) r_o_status <= pse_pkg::ST_MANY;
                            else begin
                                r_o_status <= pse_pkg::ST_OK;
                                r_o_value  <= r_top;
                            end
                            r_count <= '0;
                            r_err   <= pse_pkg::ST_OK;
                        end
                        default: ;
                    endcase
                end
                S_RD2: begin
                    // op2 arrives; fetch op1
                    r_raddr <= r_count[AW-1:0];
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_op2 <= r_rd;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // r_rd holds op1, r_op2 holds op2
                    r_waddr <= r_count[AW-1:0];
                    case (r_sym)
                        pse_pkg::SYM_ADD: begin
                            r_we <= 1'b1; r_wdata <= w_add;
                            if (r_count == '0) r_top <= w_add;
                            r_count <= r_count + CW'(1); r_state <= S_IDLE;
                        end
                        pse_pkg::SYM_SUB: begin
                            r_we <= 1'b1; r_wdata <= w_sub;
                            if (r_count == '0) r_top <= w_sub;
                            r_count <= r_count + CW'(1); r_state <= S_IDLE;
                        end
                        pse_pkg::SYM_MUL, pse_pkg::SYM_DIV: begin
                            if (r_sym == pse_pkg::SYM_DIV && r_op2 == 64'd0) begin
                                r_err <= pse_pkg::ST_DIV0; r_state <= S_IDLE;
                            end else if (w_done) begin
                                r_we <= 1'b1; r_wdata <= w_res;
                                if (r_count == '0) r_top <= w_res;
                                r_count <= r_count + CW'(1); r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_err <= pse_pkg::ST_ILLEGAL; r_state <= S_IDLE;
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_value = r_o_value;
    assign o_status       = r_o_status;

endmodule

// ===== hdl/pse_muldiv.sv =====
// Multi-cycle multiply (32x32 partial products) and restoring divide unit.
module pse_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_alu_req i_req,
    output logic              o_done,
    output logic [63:0]       o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    logic         r_neg;
    logic [63:0]  r_ma, r_mb;
    logic [127:0] r_acc;
    logic [2:0]   r_pp;
    logic [6:0]   r_cnt;
    logic [95:0]  r_dvd;
    logic [64:0]  r_rem;
    logic [63:0]  r_q;
    logic         r_over;
    logic         r_is_mul;
    logic [63:0]  r_res;
    logic         r_done;

    logic [31:0]  w_ma_half, w_mb_half;
    logic [63:0]  w_pp;
    logic [64:0]  w_rem_sh;
    logic [65:0]  w_rem_sub;

    // one 32x32 partial product per cycle, plus the divider's shifted remainder and trial subtract
    always_comb begin
        w_ma_half = r_pp[1] ? r_ma[63:32] : r_ma[31:0];
        w_mb_half = r_pp[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp      = 64'(w_ma_half) * 64'(w_mb_half);
        w_rem_sh  = {r_rem[63:0], r_dvd[95]};
        w_rem_sub = {1'b0, w_rem_sh} - {2'b0, r_mb};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.start) n_state = i_req.is_mul ? S_MUL : S_DIV;
            S_MUL:  if (r_pp == 3'd3) n_state = S_FIN;
            S_DIV:  if (r_cnt == 7'd95) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg    <= i_req.op_a[63] ^ i_req.op_b[63];
                r_ma     <= pse_pkg::magnitude(i_req.op_a);
                r_mb     <= pse_pkg::magnitude(i_req.op_b);
                r_is_mul <= i_req.is_mul;
                r_acc    <= '0;
                r_pp     <= '0;
                r_cnt    <= '0;
                r_rem    <= '0;
                r_q      <= '0;
                r_over   <= 1'b0;
                r_dvd    <= {pse_pkg::magnitude(i_req.op_a), 32'd0};
            end
            S_MUL: begin
                r_acc <= r_acc + (128'(w_pp) << (7'd32 * 7'(r_pp[1] + r_pp[0])));
                r_pp  <= r_pp + 3'd1;
            end
            S_DIV: begin
                r_dvd  <= {r_dvd[94:0], 1'b0};
                r_cnt  <= r_cnt + 7'd1;
                if (r_q[63]) r_over <= 1'b1;
                if (!w_rem_sub[65]) begin
                    r_rem <= w_rem_sub[64:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end
            S_FIN: begin
                if (r_is_mul)
                    r_res <= pse_pkg::signed_sat(r_acc[95:32], r_neg, |r_acc[127:96]);
                else
                    r_res <= pse_pkg::signed_sat(r_q, r_neg, r_over);
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== hdl/pse_checker.sv =====
module pse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_command,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_value,
    input logic [2:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pse_pkg::ST_OK |-> o_result_value == 64'd0)
        else $error("nonzero value with error status");

    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= pse_pkg::ST_OVERFLOW)
        else $error("bad status code");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_command == pse_pkg::CMD_END |=> o_valid)
        else $error("end token gave no result");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);
